// ----- hdl/tsqm_pkg.sv -----
// ----------------------------------------------------------------------------
// tsqm_pkg: shared types and constants
// Register map, field widths and pipeline payload types for the touch mapper.
// ----------------------------------------------------------------------------
package tsqm_pkg;

  localparam int unsigned SampleW   = 12;
  localparam int unsigned ScrXW     = 9;
  localparam int unsigned ScrYW     = 8;
  localparam int unsigned ScreenW   = 320;
  localparam int unsigned ScreenH   = 240;
  localparam int unsigned XLo       = 20;
  localparam int unsigned XHi       = 300;
  localparam int unsigned YLo       = 20;
  localparam int unsigned YHi       = 220;
  localparam int unsigned Full12    = 4095;
  localparam int unsigned AddrW     = 5;
  // numerator magnitude: 4095*280 < 2^21
  localparam int unsigned NumW      = 21;
  localparam int unsigned DenW      = 12;
  localparam int unsigned QuoW      = 21;
  localparam int unsigned InDataW   = 144;
  localparam int unsigned OutDataW  = 32;

  typedef enum logic [2:0] {
    RegCalValid  = 3'd0,
    RegSwap      = 3'd1,
    RegXLow      = 3'd2,
    RegXHigh     = 3'd3,
    RegYLow      = 3'd4,
    RegYHigh     = 3'd5,
    RegThreshold = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic                cal_valid;
    logic                swap;
    logic [SampleW-1:0]  x_low;
    logic [SampleW-1:0]  x_high;
    logic [SampleW-1:0]  y_low;
    logic [SampleW-1:0]  y_high;
    logic [SampleW-1:0]  threshold;
  } cfg_t;

  // one axis division job: sign-magnitude numerator and denominator
  typedef struct packed {
    logic            zero_span;
    logic            neg;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_job_t;

endpackage

// ----- hdl/tsqm_median5.sv -----
// ----------------------------------------------------------------------------
// tsqm_median5: median of five samples
// Combinational selection network, one compare level deep per exchange.
// ----------------------------------------------------------------------------
module tsqm_median5 (
  input  logic [tsqm_pkg::SampleW-1:0] s0_i,
  input  logic [tsqm_pkg::SampleW-1:0] s1_i,
  input  logic [tsqm_pkg::SampleW-1:0] s2_i,
  input  logic [tsqm_pkg::SampleW-1:0] s3_i,
  input  logic [tsqm_pkg::SampleW-1:0] s4_i,
  output logic [tsqm_pkg::SampleW-1:0] med_o
);
  logic [tsqm_pkg::SampleW-1:0] a0, a1, b0, b1, c0, c1, d0, d1, e;

  always_comb begin
    // sort pairs
    a0 = (s0_i < s1_i) ? s0_i : s1_i;
    a1 = (s0_i < s1_i) ? s1_i : s0_i;
    b0 = (s2_i < s3_i) ? s2_i : s3_i;
    b1 = (s2_i < s3_i) ? s3_i : s2_i;
    // drop the smallest of the two minima
    if (a0 < b0) begin
      c0 = s4_i < a1 ? s4_i : a1;
      c1 = s4_i < a1 ? a1 : s4_i;
      d0 = b0;
      d1 = b1;
    end else begin
      c0 = s4_i < b1 ? s4_i : b1;
      c1 = s4_i < b1 ? b1 : s4_i;
      d0 = a0;
      d1 = a1;
    end
    // median is the second smallest of the remaining four
    e = (c0 < d0) ? ((c1 < d0) ? c1 : d0) : ((d1 < c0) ? d1 : c0);
    med_o = e;
  end
endmodule

// ----- hdl/tsqm_div.sv -----
// ----------------------------------------------------------------------------
// tsqm_div: pipelined restoring divider
// One quotient bit per stage, unsigned magnitudes, stalls with the pipeline.
// ----------------------------------------------------------------------------
module tsqm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [tsqm_pkg::NumW-1:0]   num_i,
  input  logic [tsqm_pkg::DenW-1:0]   den_i,
  output logic [tsqm_pkg::QuoW-1:0]   quo_o
);
  localparam int unsigned N = tsqm_pkg::NumW;
  localparam int unsigned D = tsqm_pkg::DenW;

  logic [N-1:0] rem_q [N+1];
  logic [N-1:0] quo_q [N+1];
  logic [D-1:0] den_q [N+1];

  assign rem_q[0] = num_i;
  assign quo_q[0] = '0;
  assign den_q[0] = den_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned Sh = N - 1 - k;
    logic [2*N-1:0] dsh;
    logic [N-1:0] rem_d, quo_d;
    always_comb begin
      dsh   = {{N{1'b0}}, {(N-D){1'b0}}, den_q[k]} << Sh;
      rem_d = rem_q[k];
      quo_d = quo_q[k];
      if ({{N{1'b0}}, rem_q[k]} >= dsh) begin
        rem_d = rem_q[k] - dsh[N-1:0];
        quo_d[Sh] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rem_q[k+1] <= '0;
        quo_q[k+1] <= '0;
        den_q[k+1] <= '0;
      end else if (en_i) begin
        rem_q[k+1] <= rem_d;
        quo_q[k+1] <= quo_d;
        den_q[k+1] <= den_q[k];
      end
    end
  end

  assign quo_o = quo_q[N];
endmodule

// ----- hdl/tsqm_front.sv -----
// ----------------------------------------------------------------------------
// tsqm_front: qualify and prepare
// Pressure, touch qualification, medians, axis swap and division setup.
// ----------------------------------------------------------------------------
module tsqm_front (
  input  tsqm_pkg::cfg_t                 cfg_i,
  input  logic [tsqm_pkg::InDataW-1:0]   data_i,
  output logic                           touch_o,
  output logic [tsqm_pkg::SampleW-1:0]   press_o,
  output tsqm_pkg::div_job_t             xjob_o,
  output tsqm_pkg::div_job_t             yjob_o
);
  localparam int unsigned W = tsqm_pkg::SampleW;
  logic [W-1:0] z1, z2, mx, my, sx, sy;
  logic [W:0]   psum;

  assign z1 = data_i[W-1:0];
  assign z2 = data_i[2*W-1:W];

  tsqm_median5 u_mx (.s0_i(data_i[3*W-1:2*W]), .s1_i(data_i[4*W-1:3*W]),
    .s2_i(data_i[5*W-1:4*W]), .s3_i(data_i[6*W-1:5*W]), .s4_i(data_i[7*W-1:6*W]),
    .med_o(mx));
  tsqm_median5 u_my (.s0_i(data_i[8*W-1:7*W]), .s1_i(data_i[9*W-1:8*W]),
    .s2_i(data_i[10*W-1:9*W]), .s3_i(data_i[11*W-1:10*W]), .s4_i(data_i[12*W-1:11*W]),
    .med_o(my));

  function automatic tsqm_pkg::div_job_t mk_job(logic [W-1:0] raw, logic [W-1:0] lo,
                                                 logic [W-1:0] hi, logic [8:0] span);
    tsqm_pkg::div_job_t j;
    logic signed [W:0] a, b;
    logic [W-1:0] am, bm;
    a = $signed({1'b0, raw}) - $signed({1'b0, lo});
    b = $signed({1'b0, hi}) - $signed({1'b0, lo});
    am = a[W] ? W'(-a) : a[W-1:0];
    bm = b[W] ? W'(-b) : b[W-1:0];
    j.zero_span = (b == '0);
    j.neg = a[W] ^ b[W];
    j.num = tsqm_pkg::NumW'(am * span);
    j.den = bm;
    return j;
  endfunction

  always_comb begin
    psum = {1'b0, z1} + {1'b0, ~z2};
    press_o = psum[W] ? {W{1'b1}} : psum[W-1:0];
    touch_o = (press_o >= cfg_i.threshold) && (z1 != '0) && (z1 != {W{1'b1}})
              && cfg_i.cal_valid;
    sx = cfg_i.swap ? my : mx;
    sy = cfg_i.swap ? mx : my;
    xjob_o = mk_job(sx, cfg_i.x_low, cfg_i.x_high, 9'(tsqm_pkg::XHi - tsqm_pkg::XLo));
    yjob_o = mk_job(sy, cfg_i.y_low, cfg_i.y_high, 9'(tsqm_pkg::YHi - tsqm_pkg::YLo));
  end
endmodule

// ----- hdl/touch_sample_qualify_and_map.sv -----
// ----------------------------------------------------------------------------
// touch_sample_qualify_and_map: resistive touch qualify and calibrate
// Pipeline: 23 register stages (1 front register, 21 divider stages,
// 1 output register).
// Throughput: one item per cycle while the output is not stalled; the divider is fully pipelined.
// Reset: async active-low; config registers return to defaults, pipeline empties.
// ----------------------------------------------------------------------------
module touch_sample_qualify_and_map (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // z1, z2, x_sample_0..4, y_sample_0..4 (12 bits each, low to high)
  input  logic [tsqm_pkg::InDataW-1:0]       s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // touched[0], screen_x[9:1], screen_y[17:10], pressure_value[29:18], zero pad
  output logic [tsqm_pkg::OutDataW-1:0]      m_axis_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tsqm_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  localparam int unsigned W  = tsqm_pkg::SampleW;
  localparam int unsigned DL = tsqm_pkg::NumW;

  tsqm_pkg::cfg_t cfg_q;
  logic [2:0] ridx;
  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{cal_valid: 1'b0, swap: 1'b0, x_low: 12'd300, x_high: 12'd3800,
                 y_low: 12'd300, y_high: 12'd3800, threshold: 12'd350};
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (ridx)
        tsqm_pkg::RegCalValid:  cfg_q.cal_valid <= pwdata[0];
        tsqm_pkg::RegSwap:      cfg_q.swap      <= pwdata[0];
        tsqm_pkg::RegXLow:      cfg_q.x_low     <= pwdata[W-1:0];
        tsqm_pkg::RegXHigh:     cfg_q.x_high    <= pwdata[W-1:0];
        tsqm_pkg::RegYLow:      cfg_q.y_low     <= pwdata[W-1:0];
        tsqm_pkg::RegYHigh:     cfg_q.y_high    <= pwdata[W-1:0];
        tsqm_pkg::RegThreshold: cfg_q.threshold <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (ridx)
      tsqm_pkg::RegCalValid:  prdata[0]     = cfg_q.cal_valid;
      tsqm_pkg::RegSwap:      prdata[0]     = cfg_q.swap;
      tsqm_pkg::RegXLow:      prdata[W-1:0] = cfg_q.x_low;
      tsqm_pkg::RegXHigh:     prdata[W-1:0] = cfg_q.x_high;
      tsqm_pkg::RegYLow:      prdata[W-1:0] = cfg_q.y_low;
      tsqm_pkg::RegYHigh:     prdata[W-1:0] = cfg_q.y_high;
      tsqm_pkg::RegThreshold: prdata[W-1:0] = cfg_q.threshold;
      default: ;
    endcase
    if (paddr[1:0] != 2'b00) prdata = '0;
  end

  // pipeline advances whenever the output register is free or drains
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic touch_c;
  logic [W-1:0] press_c;
  tsqm_pkg::div_job_t xjob_c, yjob_c;

  tsqm_front u_front (.cfg_i(cfg_q), .data_i(s_axis_tdata), .touch_o(touch_c),
    .press_o(press_c), .xjob_o(xjob_c), .yjob_o(yjob_c));

  // stage 1 register
  logic st1_vld_q, st1_touch_q;
  logic [W-1:0] st1_press_q;
  tsqm_pkg::div_job_t st1_x_q, st1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_vld_q <= 1'b0;
    end else if (adv) begin
      st1_vld_q <= s_axis_tvalid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      st1_touch_q <= touch_c;
      st1_press_q <= press_c;
      st1_x_q     <= xjob_c;
      st1_y_q     <= yjob_c;
    end
  end

  logic [tsqm_pkg::QuoW-1:0] xq, yq;
  tsqm_div u_divx (.clk_i, .rst_ni, .en_i(adv), .num_i(st1_x_q.num),
    .den_i(st1_x_q.den), .quo_o(xq));
  tsqm_div u_divy (.clk_i, .rst_ni, .en_i(adv), .num_i(st1_y_q.num),
    .den_i(st1_y_q.den), .quo_o(yq));

  // side band delay matching the divider
  logic [DL:0]  vld_q;
  logic [DL:0]  touch_q, xz_q, xn_q, yz_q, yn_q;
  logic [W-1:0] press_q [1:DL];

  assign vld_q[0]   = st1_vld_q;
  assign touch_q[0] = st1_touch_q;
  assign xz_q[0]    = st1_x_q.zero_span;
  assign xn_q[0]    = st1_x_q.neg;
  assign yz_q[0]    = st1_y_q.zero_span;
  assign yn_q[0]    = st1_y_q.neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[DL:1] <= '0;
    end else if (adv) begin
      vld_q[DL:1] <= vld_q[DL-1:0];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      touch_q[DL:1] <= touch_q[DL-1:0];
      xz_q[DL:1]    <= xz_q[DL-1:0];
      xn_q[DL:1]    <= xn_q[DL-1:0];
      yz_q[DL:1]    <= yz_q[DL-1:0];
      yn_q[DL:1]    <= yn_q[DL-1:0];
      press_q[1]    <= st1_press_q;
      for (int i = 2; i <= DL; i++) press_q[i] <= press_q[i-1];
    end
  end

  // finish stage: sign, offset, clamp
  function automatic logic [9:0] finish(logic [tsqm_pkg::QuoW-1:0] q, logic neg,
                                        logic zs, logic [9:0] lo, logic [9:0] top);
    logic signed [tsqm_pkg::QuoW+1:0] v;
    logic [9:0] r;
    v = neg ? ($signed({2'b00, lo}) - $signed({2'b00, q}))
            : ($signed({2'b00, lo}) + $signed({2'b00, q}));
    if (zs) v = $signed({{(tsqm_pkg::QuoW-8){1'b0}}, lo});
    if (v < 0) r = '0;
    else if (v > $signed({{(tsqm_pkg::QuoW-8){1'b0}}, top})) r = top;
    else r = v[9:0];
    return r;
  endfunction

  logic [9:0] fx, fy;
  assign fx = finish(xq, xn_q[DL], xz_q[DL], 10'(tsqm_pkg::XLo), 10'(tsqm_pkg::ScreenW-1));
  assign fy = finish(yq, yn_q[DL], yz_q[DL], 10'(tsqm_pkg::YLo), 10'(tsqm_pkg::ScreenH-1));

  logic out_vld_q;
  logic [tsqm_pkg::OutDataW-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[DL];
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= '0;
      if (touch_q[DL]) begin
        out_q <= {2'b00, press_q[DL], fy[7:0], fx[8:0], 1'b1};
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_notouch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[29:1] == '0))
    else $error("untouched item has nonzero fields");
  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[9:1] < 9'(tsqm_pkg::ScreenW)))
    else $error("screen_x out of range");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
endmodule
